// File: rtl/breakpoint_envelope_interpolator_unit_defines.svh
// Assertion macros for the breakpoint envelope interpolator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_UNIT_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_UNIT_DEFINES_SVH

// Clocked assertion, idle while reset is held
`define BEI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset
`define BEI_ASSERT_NEVER(label, cond, msg) \
  `BEI_ASSERT(label, !(cond), msg)

`endif

// File: rtl/bei_pkg.sv
// Shared constants, codes and control structs of the breakpoint interpolator.
// No dependencies; imported by the interfaces, controller, datapath, top level and bench.
package bei_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int CNT_W      = 7;
  localparam int BAR_W      = 16;
  localparam int LVL_W      = 17;
  localparam int STEP_W     = 5;
  localparam int CODE_W     = 3;
  localparam int ENTRY_W    = BAR_W + LVL_W;
  localparam int PROG_W     = BAR_W + STEP_W;
  localparam int REM_W      = PROG_W + 1;
  localparam int PROD_W     = LVL_W + PROG_W;
  localparam int DCNT_W     = $clog2(PROD_W);

  localparam logic [LVL_W-1:0]  LEVEL_ONE = LVL_W'(65536);
  localparam logic [ADDR_W-1:0] MAX_ADDR  = ADDR_W'(MAX_POINTS);
  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(PROD_W - 1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CODE_W-1:0] CASE_EMPTY  = 3'd0;
  localparam logic [CODE_W-1:0] CASE_BEFORE = 3'd1;
  localparam logic [CODE_W-1:0] CASE_AFTER  = 3'd2;
  localparam logic [CODE_W-1:0] CASE_SAME   = 3'd3;
  localparam logic [CODE_W-1:0] CASE_INTERP = 3'd4;

  typedef struct packed {
    logic in_ready;
    logic ram_we;
    logic start;
    logic scan;
    logic mul;
    logic div;
    logic out_load;
  } bei_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_interp;
    logic div_done;
    logic out_valid;
  } bei_sts_t;

endpackage

// File: rtl/bei_if.sv
// Handshake channels of the breakpoint interpolator: request, result, config.
// Depends on bei_pkg for field widths.
interface bei_in_if import bei_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [BAR_W-1:0]   entry_bar;
  logic [LVL_W-1:0]   entry_value;
  logic [BAR_W-1:0]   beat;
  logic [STEP_W-1:0]  step;

  modport source(output valid, req_type, entry_index, entry_bar, entry_value, beat, step,
                 input ready);
  modport sink(input valid, req_type, entry_index, entry_bar, entry_value, beat, step,
               output ready);
endinterface

interface bei_out_if import bei_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LVL_W-1:0]  level;
  logic [CODE_W-1:0] case_code;

  modport source(output valid, level, case_code, input ready);
  modport sink(input valid, level, case_code, output ready);
endinterface

interface bei_cfg_if import bei_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: rtl/bei_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bei_ctrl.sv
// Sequencer of the breakpoint interpolator: accept, scan, multiply, divide, emit.
// Depends on bei_pkg for the command and status structs.
module bei_ctrl import bei_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_req_type_i,
  input  logic     out_ready_i,
  input  bei_sts_t sts_i,
  output bei_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.ram_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.need_interp ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!sts_i.out_valid || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/bei_dp.sv
// Datapath: breakpoint table, search registers, multiplier, serial divider, output.
// Depends on bei_pkg and bei_ram.
module bei_dp import bei_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bei_cmd_t          cmd_i,
  output bei_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [BAR_W-1:0]  entry_bar_i,
  input  logic [LVL_W-1:0]  entry_value_i,
  input  logic [BAR_W-1:0]  beat_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [LVL_W-1:0]  level_o,
  output logic [CODE_W-1:0] case_code_o
);

  logic [CNT_W-1:0]  count_q;
  logic [BAR_W-1:0]  beat_q;
  logic [STEP_W-1:0] step_q;
  logic [ADDR_W-1:0] addr_q;
  logic              rvalid_q;
  logic              have_prev_q, have_next_q;
  logic [BAR_W-1:0]  prev_bar_q, next_bar_q;
  logic [LVL_W-1:0]  prev_lvl_q, next_lvl_q;
  logic [PROD_W-1:0] dq_q;
  logic [REM_W-1:0]  rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              out_valid_q;
  logic [LVL_W-1:0]  level_q;
  logic [CODE_W-1:0] code_q;

  logic [LVL_W-1:0]   wr_lvl;
  logic [ENTRY_W-1:0] rdata;
  logic [BAR_W-1:0]   rd_bar;
  logic [LVL_W-1:0]   rd_lvl;
  logic [ADDR_W-1:0]  n_lim;
  logic               rd_more;
  logic [CODE_W-1:0]  code_c;
  logic               rise;
  logic [LVL_W-1:0]   mag;
  logic [PROG_W-1:0]  prog;
  logic [PROG_W-1:0]  span;
  logic [PROD_W-1:0]  prod;
  logic [REM_W-1:0]   rem_sh;
  logic               fits;
  logic [LVL_W-1:0]   headroom;
  logic [LVL_W-1:0]   interp_lvl;
  logic [LVL_W-1:0]   level_c;

  // clamp the stored level to one
  assign wr_lvl = (entry_value_i > LEVEL_ONE) ? LEVEL_ONE : entry_value_i;

  bei_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we && ({1'b0, entry_index_i} < MAX_ADDR)),
    .waddr_i(entry_index_i),
    .wdata_i({entry_bar_i, wr_lvl}),
    .raddr_i(addr_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign rd_bar = rdata[ENTRY_W-1:LVL_W];
  assign rd_lvl = rdata[LVL_W-1:0];

  // searched entries: the count register, limited to the table size
  assign n_lim   = (ADDR_W'(count_q) > MAX_ADDR) ? MAX_ADDR : ADDR_W'(count_q);
  assign rd_more = addr_q < n_lim;

  // classify from the search flags
  always_comb begin
    if (!have_prev_q && !have_next_q) begin
      code_c = CASE_EMPTY;
    end else if (!have_prev_q) begin
      code_c = CASE_BEFORE;
    end else if (!have_next_q) begin
      code_c = CASE_AFTER;
    end else if (next_bar_q == prev_bar_q) begin
      code_c = CASE_SAME;
    end else begin
      code_c = CASE_INTERP;
    end
  end

  // interpolation operands, positions in thirty-seconds of a beat
  assign rise = next_lvl_q >= prev_lvl_q;
  assign mag  = rise ? (next_lvl_q - prev_lvl_q) : (prev_lvl_q - next_lvl_q);
  assign prog = {beat_q - prev_bar_q, step_q};
  assign span = {next_bar_q - prev_bar_q, {STEP_W{1'b0}}};
  assign prod = PROD_W'(mag) * PROD_W'(prog);

  // one restoring divide step
  assign rem_sh = {rem_q[REM_W-2:0], dq_q[PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, span};

  // apply the quotient and clamp to the level range
  assign headroom = LEVEL_ONE - prev_lvl_q;
  always_comb begin
    if (rise) begin
      interp_lvl = (dq_q > PROD_W'(headroom)) ? LEVEL_ONE
                                              : prev_lvl_q + dq_q[LVL_W-1:0];
    end else begin
      interp_lvl = (dq_q > PROD_W'(prev_lvl_q)) ? '0
                                                : prev_lvl_q - dq_q[LVL_W-1:0];
    end
  end

  always_comb begin
    case (code_c) inside
      CASE_EMPTY:              level_c = '0;
      CASE_AFTER:              level_c = prev_lvl_q;
      CASE_BEFORE, CASE_SAME:  level_c = next_lvl_q;
      default:                 level_c = interp_lvl;
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // scan control: address counter, read-valid flag and neighbor-found flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      have_prev_q <= 1'b0;
      have_next_q <= 1'b0;
    end else if (cmd_i.start) begin
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      have_prev_q <= 1'b0;
      have_next_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.scan && rd_more;
      if (cmd_i.scan && rd_more) begin
        addr_q <= addr_q + 1'b1;
      end
      if (rvalid_q && rd_bar <= beat_q) begin
        have_prev_q <= 1'b1;
      end
      if (rvalid_q && !have_next_q && rd_bar >= beat_q) begin
        have_next_q <= 1'b1;
      end
    end
  end

  // query position and the neighbors found so far
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      beat_q <= beat_i;
      step_q <= step_i;
    end
    if (rvalid_q && rd_bar <= beat_q) begin
      prev_bar_q <= rd_bar;
      prev_lvl_q <= rd_lvl;
    end
    if (rvalid_q && !have_next_q && rd_bar >= beat_q) begin
      next_bar_q <= rd_bar;
      next_lvl_q <= rd_lvl;
    end
  end

  // product, then quotient shifted in over the dividend
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dq_q  <= prod;
      rem_q <= '0;
    end else if (cmd_i.div) begin
      rem_q <= fits ? (rem_sh - {1'b0, span}) : rem_sh;
      dq_q  <= {dq_q[PROD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.mul) begin
      dcnt_q <= '0;
    end else if (cmd_i.div) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      level_q <= level_c;
      code_q  <= code_c;
    end
  end

  assign sts_o.scan_done   = !rd_more && !rvalid_q;
  assign sts_o.need_interp = code_c == CASE_INTERP;
  assign sts_o.div_done    = dcnt_q == DIV_LAST;
  assign sts_o.out_valid   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign case_code_o = code_q;

endmodule

// File: rtl/breakpoint_envelope_interpolator_unit.sv
// Write word: gives no result; the next word is taken the cycle after.
// Query word: the scan makes one table read per cycle over the n searched entries (at most
// 64); an interpolated result then takes a multiply and a 38-step divider. One query at
// a time; a finished result waits in the output register while words are taken, and a
// later query holds until it leaves.
// Reset (rst_ni low, asynchronous) clears control and the entry count; table stays undefined.
`include "breakpoint_envelope_interpolator_unit_defines.svh"

module breakpoint_envelope_interpolator_unit import bei_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  bei_in_if.sink     in_i,
  bei_out_if.source  out_o,
  bei_cfg_if.sink    cfg_i
);

  bei_cmd_t cmd;
  bei_sts_t sts;
  logic     query_fire;
  logic     out_stall;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd.in_ready;

  bei_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_req_type_i(in_i.req_type),
    .out_ready_i  (out_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  bei_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .entry_index_i(in_i.entry_index),
    .entry_bar_i  (in_i.entry_bar),
    .entry_value_i(in_i.entry_value),
    .beat_i       (in_i.beat),
    .step_i       (in_i.step),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .level_o      (out_o.level),
    .case_code_o  (out_o.case_code)
  );

  // handshake terms for the checks
  assign query_fire = in_i.valid && in_i.ready && (in_i.req_type == REQ_QUERY);
  assign out_stall  = out_o.valid && !out_o.ready;

  // a result never overwrites one still waiting
  `BEI_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_stall, "result overwritten")
  // an accepted query makes the block busy
  `BEI_ASSERT(a_query_busy, query_fire |=> !in_i.ready, "input taken while busy")
  // results stay within one
  `BEI_ASSERT(a_level_range, out_o.valid |-> out_o.level <= LEVEL_ONE, "level above one")
  // divider runs only on an interpolated case
  `BEI_ASSERT(a_div_interp, cmd.div |-> sts.need_interp, "divide without interpolation")

endmodule

// File: sim/breakpoint_envelope_interpolator_unit_tb.sv
// Self-checking bench for the breakpoint envelope interpolator: table writes, position
// queries and point count settings, checked word by word against a local level predictor.
// Depends on bei_pkg, the bei_*_if channels and the breakpoint_envelope_interpolator_unit RTL.
module breakpoint_envelope_interpolator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bei_pkg::*;

  // Count plan markers for the random phases
  localparam int PLAN_PREFIX = -1;
  localparam int PLAN_RANDOM = -2;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 117;
  localparam int SETTLE_CYC  = 16;
  localparam int TAIL_CYC    = 150;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [BAR_W-1:0]  entry_bar;
    logic [LVL_W-1:0]  entry_value;
    logic [BAR_W-1:0]  beat;
    logic [STEP_W-1:0] step;
  } envelope_word_t;

  // Shadow table, point count and queue of expected levels
  class envelope_scoreboard;
    typedef struct packed {
      logic [LVL_W-1:0]  level;
      logic [CODE_W-1:0] code;
    } level_result_t;

    logic [BAR_W-1:0] entry_bar [MAX_POINTS];
    logic [LVL_W-1:0] entry_level [MAX_POINTS];
    logic [CNT_W-1:0] point_count;
    level_result_t    pending_levels [$];
    int unsigned      error_count;

    function new();
      point_count = '0;
      error_count = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      point_count = value;
    endfunction

    // Find the bracketing points and interpolate between them
    function level_result_t interpolate_level(logic [BAR_W-1:0] beat, logic [STEP_W-1:0] step);
      int          searched;
      bit          have_prev;
      bit          have_next;
      bit          rising;
      int          prev_idx;
      int          next_idx;
      logic [63:0] prog;
      logic [63:0] span;
      logic [63:0] mag;
      logic [63:0] quot;
      longint      sum;
      level_result_t res;
      searched  = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
      have_prev = 1'b0;
      have_next = 1'b0;
      prev_idx  = 0;
      next_idx  = 0;
      for (int i = 0; i < searched; i++) begin
        if (entry_bar[i] <= beat) begin
          have_prev = 1'b1;
          prev_idx  = i;
        end
        if (!have_next && entry_bar[i] >= beat) begin
          have_next = 1'b1;
          next_idx  = i;
        end
      end
      if (!have_prev && !have_next) begin
        res.level = '0;
        res.code  = CASE_EMPTY;
      end else if (!have_prev) begin
        res.level = entry_level[next_idx];
        res.code  = CASE_BEFORE;
      end else if (!have_next) begin
        res.level = entry_level[prev_idx];
        res.code  = CASE_AFTER;
      end else if (entry_bar[next_idx] == entry_bar[prev_idx]) begin
        res.level = entry_level[next_idx];
        res.code  = CASE_SAME;
      end else begin
        // Positions in thirty-seconds of a beat; quotient truncates toward zero
        prog   = (64'(beat) - 64'(entry_bar[prev_idx])) * 64'd32 + 64'(step);
        span   = (64'(entry_bar[next_idx]) - 64'(entry_bar[prev_idx])) * 64'd32;
        rising = entry_level[next_idx] >= entry_level[prev_idx];
        mag    = rising ? 64'(entry_level[next_idx]) - 64'(entry_level[prev_idx])
                        : 64'(entry_level[prev_idx]) - 64'(entry_level[next_idx]);
        quot   = (mag * prog) / span;
        sum    = longint'(entry_level[prev_idx]);
        if (rising) sum = sum + longint'(quot);
        else sum = sum - longint'(quot);
        // Clamp extrapolation past the next point
        if (sum < 0) res.level = '0;
        else if (sum > longint'(LEVEL_ONE)) res.level = LEVEL_ONE;
        else res.level = LVL_W'(sum);
        res.code = CASE_INTERP;
      end
      return res;
    endfunction

    // Store a written point, or queue the level a query should return
    function void note_word(envelope_word_t word);
      if (word.req_type == REQ_WRITE) begin
        entry_bar[word.entry_index]   = word.entry_bar;
        entry_level[word.entry_index] = (word.entry_value > LEVEL_ONE) ? LEVEL_ONE
                                                                       : word.entry_value;
      end else begin
        pending_levels.push_back(interpolate_level(word.beat, word.step));
      end
    endfunction

    // Compare one result word with the oldest expected level
    function void check_result(logic [LVL_W-1:0] level, logic [CODE_W-1:0] code);
      level_result_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result word, level %0d case %0d", $time, level, code);
        error_count++;
        return;
      end
      want = pending_levels.pop_front();
      if (level !== want.level) begin
        $display("%0t: level mismatch, expected %0d actual %0d", $time, want.level, level);
        error_count++;
      end
      if (code !== want.code) begin
        $display("%0t: case mismatch, expected %0d actual %0d", $time, want.code, code);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  bit          written [MAX_POINTS];
  int          count_plan [PHASES] = '{PLAN_PREFIX, 1, PLAN_RANDOM, 64, 0, PLAN_RANDOM, 127,
                                       PLAN_PREFIX, 64};

  envelope_scoreboard board = new();

  bei_in_if  in_if();
  bei_out_if out_if();
  bei_cfg_if cfg_if();

  breakpoint_envelope_interpolator_unit i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      board.check_result(out_if.level, out_if.case_code);
    end
  end

  function automatic int first_unwritten();
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (!written[i]) return i;
    end
    return MAX_POINTS;
  endfunction

  function automatic envelope_word_t write_word(input int idx, input int bar, input int value);
    envelope_word_t w;
    w.req_type    = REQ_WRITE;
    w.entry_index = IDX_W'(idx);
    w.entry_bar   = BAR_W'(bar);
    w.entry_value = LVL_W'(value);
    w.beat        = BAR_W'($urandom);
    w.step        = STEP_W'($urandom);
    written[idx]  = 1'b1;
    return w;
  endfunction

  function automatic envelope_word_t query_word(input int beat, input int step);
    envelope_word_t w;
    w.req_type    = REQ_QUERY;
    w.entry_index = IDX_W'($urandom);
    w.entry_bar   = BAR_W'($urandom);
    w.entry_value = LVL_W'($urandom);
    w.beat        = BAR_W'(beat);
    w.step        = STEP_W'(step);
    return w;
  endfunction

  // Mix of table writes and queries aimed near the stored bars
  function automatic envelope_word_t random_word();
    int pick;
    int idx;
    int bar;
    int value;
    int beat;
    int step;
    int hole;
    int searched;
    if ($urandom_range(0, 99) < 45) begin
      hole = first_unwritten();
      if (hole < MAX_POINTS && $urandom_range(0, 1) == 1) idx = hole;
      else idx = $urandom_range(0, MAX_POINTS - 1);
      pick = $urandom_range(0, 9);
      if (pick < 4) bar = $urandom_range(0, 40);
      else if (pick < 8) bar = $urandom_range(0, 65535);
      else bar = (pick == 8) ? 0 : 65535;
      pick = $urandom_range(0, 9);
      if (pick == 0) value = 0;
      else if (pick == 1) value = 65536;
      else if (pick == 2) value = $urandom_range(65537, 131071);
      else value = $urandom_range(0, 65536);
      return write_word(idx, bar, value);
    end
    searched = (board.point_count > MAX_POINTS) ? MAX_POINTS : int'(board.point_count);
    pick = $urandom_range(0, 9);
    if (pick < 5 && searched > 0) begin
      beat = int'(board.entry_bar[$urandom_range(0, searched - 1)]) +
             int'($urandom_range(0, 4)) - 2;
      if (beat < 0) beat = 0;
      if (beat > 65535) beat = 65535;
    end else if (pick < 7) begin
      beat = $urandom_range(0, 40);
    end else if (pick < 9) begin
      beat = $urandom_range(0, 65535);
    end else begin
      beat = ($urandom_range(0, 1) == 1) ? 65535 : 0;
    end
    pick = $urandom_range(0, 4);
    if (pick == 0) step = 0;
    else if (pick == 1) step = 31;
    else step = $urandom_range(0, 31);
    return query_word(beat, step);
  endfunction

  // Offer one word, with random idle cycles ahead of it; enter and leave at a falling edge
  task automatic send_word(input envelope_word_t word);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= word.req_type;
    in_if.entry_index <= word.entry_index;
    in_if.entry_bar   <= word.entry_bar;
    in_if.entry_value <= word.entry_value;
    in_if.beat        <= word.beat;
    in_if.step        <= word.step;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_word(word);
    @(negedge clk);
  endtask

  // Drain all queries, let the last write settle, then set the point count
  task automatic write_count(input logic [CNT_W-1:0] value);
    in_if.valid <= 1'b0;
    while (board.pending_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.set_count(value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int prefix;
    int value;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_WRITE;
    in_if.entry_index = '0;
    in_if.entry_bar   = '0;
    in_if.entry_value = '0;
    in_if.beat        = '0;
    in_if.step        = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table at both ends of the position range
    send_word(query_word(0, 0));
    send_word(query_word(65535, 31));

    // Duplicate bar, level above one, top bar, out-of-order bar, last index
    send_word(write_word(0, 100, 0));
    send_word(write_word(1, 100, 40000));
    send_word(write_word(2, 200, 131071));
    send_word(write_word(3, 65535, 65536));
    send_word(write_word(4, 150, 1000));
    send_word(write_word(MAX_POINTS - 1, 0, 65535));

    // Before first, same bar, interpolated, after last
    write_count(3);
    send_word(query_word(50, 3));
    send_word(query_word(100, 7));
    send_word(query_word(150, 16));
    send_word(query_word(65535, 31));
    send_word(query_word(0, 0));

    // Step past the next point, clamped at one, then a query on the top bar
    write_count(5);
    send_word(query_word(200, 31));
    send_word(query_word(65535, 31));

    // Step past the next point on a falling edge, clamped at zero
    send_word(write_word(0, 300, 0));
    send_word(write_word(5, 299, 65536));
    write_count(6);
    send_word(query_word(300, 31));

    // Random phases over three idle patterns and several point counts
    for (int phase = 0; phase < PHASES; phase++) begin
      in_idle_pct  = (phase / 3 == 0) ? 11 : (phase / 3 == 1) ? 53 : 0;
      out_idle_pct = (phase / 3 == 0) ? 53 : (phase / 3 == 1) ? 11 : 0;
      prefix = first_unwritten();
      if (count_plan[phase] == PLAN_PREFIX) begin
        value = prefix;
      end else if (count_plan[phase] == PLAN_RANDOM) begin
        if (prefix == MAX_POINTS && $urandom_range(0, 1) == 1) value = $urandom_range(65, 127);
        else value = $urandom_range(0, prefix);
      end else begin
        value = count_plan[phase];
      end
      // Never search an entry that has not been written
      if (prefix < MAX_POINTS && value > prefix) value = prefix;
      write_count(CNT_W'(value));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
    end

    // Drop valid, wait for the last results, then hold for stray words
    in_if.valid <= 1'b0;
    while (board.pending_levels.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (board.error_count == 0 && board.pending_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
